// ===== src/nsp_pkg.sv =====
// ----------------------------------------------------------------------------
// nsp_pkg: shared types and constants for the nearest segment pick
// Word layouts, queue entry type and distance ceiling.
// ----------------------------------------------------------------------------
`default_nettype none
package nsp_pkg;
  localparam int unsigned CoordW   = 16;
  localparam int unsigned IdW      = 16;
  localparam int unsigned ProjW    = 3;
  localparam int unsigned DistW    = 17;
  localparam logic [DistW-1:0] DistMax = '1;
  localparam int unsigned QueueDepth = 2;

  // Selected distance job: squared length, optional perpendicular numerator
  typedef struct packed {
    logic [IdW-1:0] id;
    logic           use_div;   // perpendicular: |cross| / len(ab)
    logic [33:0]    sq;        // squared length to root
    logic [32:0]    mag;       // |cross|, used only when use_div
    logic           last;
    logic           valid_seg; // projector matched
  } job_t;
endpackage
`default_nettype wire

// ===== src/nsp_front.sv =====
// ----------------------------------------------------------------------------
// nsp_front: classify one segment
// Two register stages: products, then case selection into a job.
// ----------------------------------------------------------------------------
`default_nettype none
module nsp_front import nsp_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [ProjW-1:0]   proj_sel_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [IdW-1:0]     id_i,
  input  wire logic [ProjW-1:0]   proj_i,
  input  wire logic signed [CoordW-1:0] ax_i, ay_i, bx_i, by_i, cx_i, cy_i,
  input  wire logic               last_i,
  output logic                    job_valid_o,
  input  wire logic               job_ready_i,
  output job_t                    job_o
);
  // stage 1 products
  logic s1_q, s1_d;
  logic signed [16:0] abx, aby, bcx, bcy, acx, acy;
  logic signed [33:0] ac_sq;
  logic signed [33:0] p_q [8];
  logic [IdW-1:0] id_q;
  logic last_q, match_q, zero_q;
  logic s2_q;
  job_t job_q, job_d;

  assign abx = 17'(bx_i) - 17'(ax_i);
  assign aby = 17'(by_i) - 17'(ay_i);
  assign bcx = 17'(cx_i) - 17'(bx_i);
  assign bcy = 17'(cy_i) - 17'(by_i);
  assign acx = 17'(cx_i) - 17'(ax_i);
  assign acy = 17'(cy_i) - 17'(ay_i);
  assign ac_sq = acx * acx + acy * acy;

  assign in_ready_o  = !s1_q && !s2_q;
  assign s1_d        = in_valid_i && in_ready_o;
  assign job_valid_o = s2_q;
  assign job_o       = job_q;

  always_ff @(posedge clk_i) begin
    if (s1_d) begin
      p_q[0] <= abx * bcx;  p_q[1] <= aby * bcy;
      p_q[2] <= abx * acx;  p_q[3] <= aby * acy;
      p_q[4] <= abx * acy;  p_q[5] <= aby * acx;
      p_q[6] <= bcx * bcx;
      p_q[7] <= bcy * bcy;
      id_q <= id_i; last_q <= last_i; match_q <= (proj_i == proj_sel_i);
      zero_q <= (abx == 0) && (aby == 0);
      job_q.sq <= ac_sq;
    end else if (s1_q) begin
      job_q <= job_d;
    end
  end

  logic signed [35:0] dot1, dot2, crs;
  always_comb begin
    dot1 = 36'(p_q[0]) + 36'(p_q[1]);
    dot2 = 36'(p_q[2]) + 36'(p_q[3]);
    crs  = 36'(p_q[4]) - 36'(p_q[5]);
    job_d = job_q;
    job_d.id = id_q; job_d.last = last_q; job_d.valid_seg = match_q;
    job_d.use_div = 1'b0;
    job_d.mag = '0;
    if (dot1 > 0) begin
      job_d.sq = 34'(p_q[6]) + 34'(p_q[7]);
    end else if (dot2 < 0 || zero_q) begin
      job_d.sq = job_q.sq;   // |AC|^2
    end else begin
      job_d.use_div = 1'b1;
      job_d.mag = crs < 0 ? 33'(-crs) : 33'(crs);
      job_d.sq = 34'(dot2 - dot1);  // |AB|^2 = AB.AC - AB.BC
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0; s2_q <= 1'b0;
    end else begin
      s1_q <= s1_d;
      if (s1_q) s2_q <= 1'b1;
      else if (job_ready_i) s2_q <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ===== src/nsp_back.sv =====
// ----------------------------------------------------------------------------
// nsp_back: root, divide and keep the best
// Two-entry queue, bit-serial root and restoring divider, result register.
// ----------------------------------------------------------------------------
`default_nettype none
module nsp_back import nsp_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             job_valid_i,
  output logic                  job_ready_o,
  input  wire job_t             job_i,
  output logic                  res_valid_o,
  input  wire logic             res_ready_i,
  output logic                  found_o,
  output logic [IdW-1:0]        id_o,
  output logic [DistW-1:0]      dist_o
);
  localparam logic [1:0] StIdle = 2'd0, StRoot = 2'd1, StDiv = 2'd2, StKeep = 2'd3;

  job_t q_mem [QueueDepth];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic [1:0] st_q;
  logic [5:0] it_q;
  job_t cur_q;
  logic [35:0] x_q, r_q, bit_q;
  logic [33:0] rem_q;
  logic [32:0] num_q, quo_q;
  logic [17:0] len_q;
  logic [DistW-1:0] best_q, dist_q;
  logic [IdW-1:0] bid_q;
  logic have_q, rv_q;
  logic push, pop;

  assign job_ready_o = cnt_q != 2'(QueueDepth);
  assign push = job_valid_i && job_ready_o;
  assign pop  = st_q == StIdle && cnt_q != 0 && !rv_q;
  assign res_valid_o = rv_q;

  always_ff @(posedge clk_i) if (push) q_mem[wp_q] <= job_i;

  logic [35:0] trial;
  logic [35:0] root_r;
  logic [34:0] dtrial;
  assign trial  = r_q + bit_q;
  assign root_r = (x_q > r_q) ? r_q + 36'd1 : r_q; // after loop x=s-r*r
  assign dtrial = {rem_q, num_q[32]} - {17'd0, len_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0; st_q <= StIdle; it_q <= '0;
      best_q <= DistMax; bid_q <= '0; have_q <= 1'b0; rv_q <= 1'b0;
    end else begin
      if (push) wp_q <= !wp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
      if (rv_q && res_ready_i) rv_q <= 1'b0;
      unique case (st_q)
        StIdle: if (pop) begin
          cur_q <= q_mem[rp_q]; rp_q <= !rp_q;
          x_q <= 36'(q_mem[rp_q].sq); r_q <= '0; bit_q <= 36'd1 << 34;
          it_q <= 6'd18; st_q <= StRoot;
        end
        StRoot: begin
          if (x_q >= trial) begin
            x_q <= x_q - trial; r_q <= (r_q >> 1) + bit_q;
          end else r_q <= r_q >> 1;
          bit_q <= bit_q >> 2;
          it_q <= it_q - 6'd1;
          if (it_q == 6'd1) st_q <= StDiv;
        end
        StDiv: begin
          if (it_q == 6'd0) begin
            len_q <= 18'(root_r);
            if (!cur_q.use_div || root_r == 0) begin
              dist_q <= root_r > 36'(DistMax) ? DistMax : DistW'(root_r);
              st_q <= StKeep;
            end else begin
              num_q <= cur_q.mag + 33'(root_r >> 1); rem_q <= '0; quo_q <= '0;
              it_q <= 6'd33;
            end
          end else begin
            if (!dtrial[34]) begin
              rem_q <= dtrial[33:0]; quo_q <= {quo_q[31:0], 1'b1};
            end else begin
              rem_q <= {rem_q[32:0], num_q[32]}; quo_q <= {quo_q[31:0], 1'b0};
            end
            num_q <= num_q << 1;
            if (it_q == 6'd1) begin
              it_q <= 6'd63; st_q <= StKeep;
            end else begin
              it_q <= it_q - 6'd1;
            end
          end
        end
        StKeep: begin
          logic [DistW-1:0] d;
          d = (it_q == 6'd63) ? ((quo_q > 33'(DistMax)) ? DistMax : DistW'(quo_q))
                              : dist_q;
          if (it_q == 6'd63) begin
            // quotient complete; clip it into dist_q first, keep next cycle
            it_q <= 6'd62;
          end else begin
            if (!cur_q.last && cur_q.valid_seg && (!have_q || d < best_q)) begin
              best_q <= d; bid_q <= cur_q.id; have_q <= 1'b1;
            end
            st_q <= StIdle;
            if (cur_q.last) begin
              rv_q <= 1'b1;
              found_o <= have_q || cur_q.valid_seg;
              if (cur_q.valid_seg && (!have_q || d < best_q)) begin
                id_o <= cur_q.id; dist_o <= d;
              end else begin
                id_o <= have_q ? bid_q : '0; dist_o <= have_q ? best_q : DistMax;
              end
              best_q <= DistMax; bid_q <= '0; have_q <= 1'b0;
            end
          end
          if (it_q == 6'd63)
            dist_q <= (quo_q > 33'(DistMax)) ? DistMax : DistW'(quo_q);
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'(QueueDepth))
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) rv_q && !res_ready_i |=> rv_q)
    else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !rv_q)
    else $error("job started with pending result");
endmodule
`default_nettype wire

// ===== src/nearest_segment_pick_core.sv =====
// ----------------------------------------------------------------------------
// nearest_segment_pick_core: nearest line segment to a query point
// Streams segments, reports nearest id and distance at the end of a pick.
// ----------------------------------------------------------------------------
// Input words arrive on s_axis; tlast marks the final segment of a pick,
// tuser carries the projector. Segments of another projector than cfg are
// skipped. One result word leaves on m_axis per pick, after its last word.
// The front stage takes a word (products, then selection) into a two-entry
// queue and takes no new word until the previous one has moved into it; the
// back stage works on one word at a time: 18 root steps, rounding and keep
// for a word whose distance is a root alone, and 33 quotient steps plus a
// clip step before the keep when the perpendicular divide follows, so the
// sustained rate is set by the serial root and divider. The result word
// also waits for the words queued ahead of the last word.
// Reset clears the projector select to 0 and sets the running best to DistMax.
// When m_axis stalls the result holds in its register; the back stage then
// stops taking jobs, the queue fills and s_axis_tready falls.
// ----------------------------------------------------------------------------
`default_nettype none
module nearest_segment_pick_core import nsp_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_wdata_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // id[15:0], sx, sy, ex, ey, px, py (16 bits each, sx at [31:16])
  input  wire logic [111:0] s_axis_tdata,
  input  wire logic [2:0]   s_axis_tuser,  // segment_projector
  input  wire logic         s_axis_tlast,  // last_segment
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // nearest_id[15:0], nearest_distance[32:16], zero fill
  output logic [39:0]       m_axis_tdata,
  output logic              m_axis_tuser   // found
);
  logic [ProjW-1:0] sel_q;
  logic jv, jr;
  job_t job;
  logic [IdW-1:0] rid;
  logic [DistW-1:0] rdist;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sel_q <= '0;
    else if (cfg_we_i) sel_q <= cfg_wdata_i;
  end

  nsp_front u_front (
    .clk_i, .rst_ni, .proj_sel_i(sel_q),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .id_i(s_axis_tdata[15:0]), .proj_i(s_axis_tuser),
    .ax_i(s_axis_tdata[31:16]), .ay_i(s_axis_tdata[47:32]),
    .bx_i(s_axis_tdata[63:48]), .by_i(s_axis_tdata[79:64]),
    .cx_i(s_axis_tdata[95:80]), .cy_i(s_axis_tdata[111:96]),
    .last_i(s_axis_tlast),
    .job_valid_o(jv), .job_ready_i(jr), .job_o(job)
  );

  nsp_back u_back (
    .clk_i, .rst_ni, .job_valid_i(jv), .job_ready_o(jr), .job_i(job),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .found_o(m_axis_tuser), .id_o(rid), .dist_o(rdist)
  );

  assign m_axis_tdata = {7'd0, rdist, rid};
endmodule
`default_nettype wire
